@@ rtl/bba_pkg.sv @@
// shared types and constants of the buddy block allocator
package bba_pkg;

	localparam int ORDER_W  = 5;
	localparam int SIZE_W   = 13;
	localparam int OFFSET_W = 17;
	localparam int STATUS_W = 2;

	localparam logic [ORDER_W-1:0] ORDER_LOW   = 5'd6;
	localparam logic [ORDER_W-1:0] ORDER_HIGH  = 5'd17;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd12;

	// node state codes
	localparam logic [1:0] NODE_FREE  = 2'd0;
	localparam logic [1:0] NODE_SPLIT = 2'd1;
	localparam logic [1:0] NODE_USED  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_EVAL  = 9'b000000100,
		S_SPL_L = 9'b000001000,
		S_SPL_R = 9'b000010000,
		S_BT    = 9'b000100000,
		S_MRD   = 9'b001000000,
		S_MEVAL = 9'b010000000,
		S_FIN   = 9'b100000000
	} fsm_t;

endpackage

@@ rtl/bba_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4095,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/buddy_block_allocator_unit.sv @@
// top level of the buddy block allocator: walk controller around the node ram
// walk: a bad size goes straight to the finish state; other requests pass through node reads,
// splits, backtrack steps and merge levels before the finish state loads the result
// throughput: one transaction at a time, the next one is accepted in the cycle after the result loads
// reset: root node free, segment order 12, no result pending; other nodes are not
// cleared since a node is always written when its parent splits
module buddy_block_allocator_unit
	import bba_pkg::*;
#(
	parameter int TREE_NODES  = 4095,
	parameter int MIN_BLOCK   = 64,
	parameter int MAX_REQUEST = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [ORDER_W-1:0]   cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [SIZE_W-1:0]    request_size,
	input  logic [OFFSET_W-1:0]  block_offset,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [OFFSET_W-1:0]  result_offset
);
	localparam int IDX_W = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
	localparam int CHW   = IDX_W + 2;

	fsm_t                  state_q;
	logic [ORDER_W-1:0]    order_q;
	logic [1:0]            root_q;        // root node state lives in flops
	logic [IDX_W-1:0]      idx_q;
	logic [ORDER_W-1:0]    lg_q;          // log2 of current node size
	logic [OFFSET_W-1:0]   off_q;
	logic                  act_q;
	logic [ORDER_W-1:0]    rq_lg_q;
	logic [OFFSET_W-1:0]   tgt_q;
	logic                  force_free_q;  // node just created by a split
	logic [STATUS_W-1:0]   res_st_q;
	logic [OFFSET_W-1:0]   res_off_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [OFFSET_W-1:0]   result_offset_q;

	// ram ports
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [1:0]            ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [1:0]            ram_rdata;

	bba_ram #(
		.WIDTH(2),
		.DEPTH(TREE_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// effective root order, clamped into the legal range
	logic [ORDER_W-1:0] ord_eff;
	always_comb begin
		if (order_q < ORDER_LOW) ord_eff = ORDER_LOW;
		else if (order_q > ORDER_HIGH) ord_eff = ORDER_HIGH;
		else ord_eff = order_q;
	end

	// request size check and log2
	logic                 req_pow2;
	logic                 req_ok;
	logic [ORDER_W-1:0]   req_lg;
	always_comb begin
		req_pow2 = (request_size != '0) &&
			((request_size & (request_size - SIZE_W'(1))) == '0);
		req_ok = req_pow2 && ({19'b0, request_size} >= 32'(MIN_BLOCK)) &&
			({19'b0, request_size} <= 32'(MAX_REQUEST));
		req_lg = '0;
		for (int b = 0; b < SIZE_W; b++) begin
			if (request_size[b]) req_lg = ORDER_W'(b);
		end
	end

	// tree navigation
	logic [CHW-1:0]       left_w, right_w;
	logic                 right_ok;
	logic [IDX_W-1:0]     left_idx, right_sib, parent_idx, buddy_idx;
	logic [OFFSET_W:0]    size_w;
	logic [OFFSET_W-1:0]  size_off;
	logic [1:0]           node_st;
	logic                 is_root;

	always_comb begin
		left_w     = {idx_q, 1'b1} + CHW'(0);
		right_w    = left_w + CHW'(1);
		right_ok   = right_w < CHW'(TREE_NODES);
		left_idx   = left_w[IDX_W-1:0];
		right_sib  = idx_q + IDX_W'(1);
		parent_idx = (idx_q - IDX_W'(1)) >> 1;
		buddy_idx  = idx_q[0] ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
		size_w     = (OFFSET_W+1)'(1) << lg_q;
		size_off   = size_w[OFFSET_W-1:0];
		is_root    = (idx_q == '0);
		if (force_free_q) node_st = NODE_FREE;
		else if (is_root) node_st = root_q;
		else node_st = ram_rdata;
	end

	assign in_ready = (state_q == S_IDLE);

	// ram access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = NODE_FREE;
		ram_raddr = idx_q;
		unique case (state_q)
			S_EVAL: begin
				if (act_q == ACT_ALLOC) begin
					if (node_st == NODE_FREE && lg_q == rq_lg_q) begin
						ram_we    = 1'b1;
						ram_wdata = NODE_USED;
					end else if (node_st == NODE_FREE && lg_q > rq_lg_q && right_ok) begin
						ram_we    = 1'b1;
						ram_wdata = NODE_SPLIT;
					end
				end else if (node_st == NODE_USED && off_q == tgt_q) begin
					ram_we    = 1'b1;
					ram_wdata = NODE_FREE;
				end
			end
			S_SPL_L: begin
				ram_we    = 1'b1;
				ram_waddr = left_idx;
			end
			S_SPL_R: begin
				ram_we    = 1'b1;
				ram_waddr = right_w[IDX_W-1:0];
			end
			S_MRD: ram_raddr = buddy_idx;
			S_MEVAL: begin
				if (ram_rdata == NODE_FREE) begin
					ram_we    = 1'b1;
					ram_waddr = parent_idx;
				end
			end
			default: ;
		endcase
	end

	// walk controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			order_q      <= ORDER_RESET;
			root_q       <= NODE_FREE;
			out_valid_q  <= 1'b0;
			force_free_q <= 1'b0;
		end else begin
			if (cfg_wr_en) order_q <= cfg_wr_data;
			// the finish state reloads the result register itself
			if (out_valid_q && out_ready && state_q != S_FIN) out_valid_q <= 1'b0;
			// root state mirrors ram writes to node 0
			if (ram_we && ram_waddr == '0) root_q <= ram_wdata;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						rq_lg_q <= req_lg;
						tgt_q   <= block_offset;
						idx_q   <= '0;
						lg_q    <= ord_eff;
						off_q   <= '0;
						force_free_q <= 1'b0;
						if (action == ACT_ALLOC && !req_ok) begin
							res_st_q  <= ST_BAD_SIZE;
							res_off_q <= '0;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					force_free_q <= 1'b0;
					if (act_q == ACT_ALLOC) begin
						if (node_st == NODE_FREE && lg_q == rq_lg_q) begin
							res_st_q  <= ST_OK;
							res_off_q <= off_q;
							state_q   <= S_FIN;
						end else if (node_st == NODE_FREE && lg_q > rq_lg_q && right_ok) begin
							state_q <= S_SPL_L;
						end else if (node_st == NODE_SPLIT) begin
							idx_q   <= left_idx;
							lg_q    <= lg_q - ORDER_W'(1);
							state_q <= S_RD;
						end else begin
							state_q <= S_BT;
						end
					end else begin
						if (node_st == NODE_USED && off_q == tgt_q) begin
							res_st_q  <= ST_OK;
							res_off_q <= tgt_q;
							state_q   <= is_root ? S_FIN : S_MRD;
						end else if (node_st == NODE_SPLIT) begin
							idx_q   <= left_idx;
							lg_q    <= lg_q - ORDER_W'(1);
							state_q <= S_RD;
						end else begin
							state_q <= S_BT;
						end
					end
				end
				S_SPL_L: state_q <= S_SPL_R;
				S_SPL_R: begin
					// left child is known free, evaluate it without a read
					idx_q        <= left_idx;
					lg_q         <= lg_q - ORDER_W'(1);
					force_free_q <= 1'b1;
					state_q      <= S_EVAL;
				end
				S_BT: begin
					priority if (is_root) begin
						res_st_q  <= (act_q == ACT_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
						res_off_q <= (act_q == ACT_ALLOC) ? '0 : tgt_q;
						state_q   <= S_FIN;
					end else if (idx_q[0]) begin
						// left child failed, try its right sibling
						idx_q   <= right_sib;
						off_q   <= off_q + size_off;
						state_q <= S_RD;
					end else begin
						// right child failed, so its parent failed too
						idx_q <= parent_idx;
						off_q <= off_q - size_off;
						lg_q  <= lg_q + ORDER_W'(1);
					end
				end
				S_MRD: state_q <= S_MEVAL;
				S_MEVAL: begin
					if (ram_rdata == NODE_FREE) begin
						idx_q   <= parent_idx;
						lg_q    <= lg_q + ORDER_W'(1);
						state_q <= (parent_idx == '0) ? S_FIN : S_MRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						status_q        <= res_st_q;
						result_offset_q <= res_off_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_offset = result_offset_q;

endmodule
